// ===== src/rsas_pkg.sv =====
// ----------------------------------------------------------------------------
// rsas_pkg
// Types, microcode codes and the control store for the rotated sorted array
// search block.
// ----------------------------------------------------------------------------
package rsas_pkg;

  typedef struct packed {
    logic               op;
    logic [7:0]         load_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] position;
  } out_item_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;

  // step codes
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] S_PV0  = 4'd1;
  localparam logic [STEP_W-1:0] S_PV1  = 4'd2;
  localparam logic [STEP_W-1:0] S_PV2  = 4'd3;
  localparam logic [STEP_W-1:0] S_PV3  = 4'd4;
  localparam logic [STEP_W-1:0] S_PV4  = 4'd5;
  localparam logic [STEP_W-1:0] S_SL0  = 4'd6;
  localparam logic [STEP_W-1:0] S_SL1  = 4'd7;
  localparam logic [STEP_W-1:0] S_SL2  = 4'd8;
  localparam logic [STEP_W-1:0] S_BS0  = 4'd9;
  localparam logic [STEP_W-1:0] S_BS1  = 4'd10;

  // read address select
  localparam logic [2:0] AD_MID    = 3'd0;
  localparam logic [2:0] AD_MID_P1 = 3'd1;
  localparam logic [2:0] AD_MID_M1 = 3'd2;
  localparam logic [2:0] AD_LO     = 3'd3;
  localparam logic [2:0] AD_P      = 3'd4;
  localparam logic [2:0] AD_ZERO   = 3'd5;

  // jump conditions
  localparam logic [2:0] C_NONE     = 3'd0;
  localparam logic [2:0] C_LO_GE_HI = 3'd1;
  localparam logic [2:0] C_LO_GT_HI = 3'd2;
  localparam logic [2:0] C_PIV_NEXT = 3'd3;
  localparam logic [2:0] C_PIV_PREV = 3'd4;
  localparam logic [2:0] C_LEFT     = 3'd5;
  localparam logic [2:0] C_RD_EQ_V  = 3'd6;

  // datapath actions
  localparam logic [3:0] A_NOP      = 4'd0;
  localparam logic [3:0] A_P_END    = 4'd1;
  localparam logic [3:0] A_P_MID    = 4'd2;
  localparam logic [3:0] A_P_MIDM1  = 4'd3;
  localparam logic [3:0] A_NARROW_A = 4'd4;
  localparam logic [3:0] A_NARROW_V = 4'd5;
  localparam logic [3:0] A_RANGE_L  = 4'd6;
  localparam logic [3:0] A_RANGE_R  = 4'd7;
  localparam logic [3:0] A_HIT      = 4'd8;
  localparam logic [3:0] A_MISS     = 4'd9;

  typedef struct packed {
    logic [2:0]        addr_sel;
    logic              a_load;
    logic [2:0]        cond;
    logic [3:0]        act_t;
    logic [3:0]        act_f;
    logic [STEP_W-1:0] jmp_t;
    logic [STEP_W-1:0] jmp_f;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] addr_sel;
    logic       a_load;
    logic [3:0] act;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic lo_ge_hi;
    logic lo_gt_hi;
    logic piv_next;
    logic piv_prev;
    logic left;
    logic rd_eq_v;
  } flags_t;

  function automatic ctrl_t cw(input logic [2:0] ad, input logic ld, input logic [2:0] cd,
                               input logic [3:0] at, input logic [3:0] af,
                               input logic [STEP_W-1:0] jt, input logic [STEP_W-1:0] jf);
    cw = {ad, ld, cd, at, af, jt, jf};
  endfunction

  // control store: read issued in a step returns in the next one
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t c;
    case (s)
      S_PV0: c = cw(AD_MID,    1'b0, C_LO_GE_HI, A_P_END,   A_NOP,      S_SL0, S_PV1);
      S_PV1: c = cw(AD_MID_P1, 1'b1, C_NONE,     A_NOP,     A_NOP,      S_PV2, S_PV2);
      S_PV2: c = cw(AD_MID_M1, 1'b0, C_PIV_NEXT, A_P_MID,   A_NOP,      S_SL0, S_PV3);
      S_PV3: c = cw(AD_LO,     1'b0, C_PIV_PREV, A_P_MIDM1, A_NOP,      S_SL0, S_PV4);
      S_PV4: c = cw(AD_MID,    1'b0, C_NONE,     A_NOP,     A_NARROW_A, S_PV0, S_PV0);
      S_SL0: c = cw(AD_P,      1'b0, C_NONE,     A_NOP,     A_NOP,      S_SL1, S_SL1);
      S_SL1: c = cw(AD_ZERO,   1'b1, C_NONE,     A_NOP,     A_NOP,      S_SL2, S_SL2);
      S_SL2: c = cw(AD_MID,    1'b0, C_LEFT,     A_RANGE_L, A_RANGE_R,  S_BS0, S_BS0);
      S_BS0: c = cw(AD_MID,    1'b0, C_LO_GT_HI, A_MISS,    A_NOP,      S_IDLE, S_BS1);
      S_BS1: c = cw(AD_MID,    1'b0, C_RD_EQ_V,  A_HIT,     A_NARROW_V, S_IDLE, S_BS0);
      default: c = cw(AD_MID,  1'b0, C_NONE,     A_NOP,     A_NOP,      S_IDLE, S_IDLE);
    endcase
    return c;
  endfunction

endpackage

// ===== src/rsas_seq.sv =====
// ----------------------------------------------------------------------------
// rsas_seq
// Microcode sequencer: step counter, control store lookup and conditional
// jumps. Issues one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module rsas_seq import rsas_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    op,
  input  flags_t  flags,
  output logic    busy,
  output dp_cmd_t cmd
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_t             cword;
  logic              taken;

  assign cword = ucode(step);
  assign busy  = (step != S_IDLE);

  always_comb begin
    case (cword.cond)
      C_NONE:     taken = 1'b0;
      C_LO_GE_HI: taken = flags.lo_ge_hi;
      C_LO_GT_HI: taken = flags.lo_gt_hi;
      C_PIV_NEXT: taken = flags.piv_next;
      C_PIV_PREV: taken = flags.piv_prev;
      C_LEFT:     taken = flags.left;
      C_RD_EQ_V:  taken = flags.rd_eq_v;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    if (step == S_IDLE) begin
      step_next = (start && (op == OP_QUERY) && !flags.cnt_zero) ? S_PV0 : S_IDLE;
    end else begin
      step_next = taken ? cword.jmp_t : cword.jmp_f;
    end
  end

  assign cmd.addr_sel = cword.addr_sel;
  assign cmd.a_load   = cword.a_load;
  assign cmd.act      = taken ? cword.act_t : cword.act_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== src/rsas_dp.sv =====
// ----------------------------------------------------------------------------
// rsas_dp
// Datapath: element memory with one registered read port, search bounds,
// pivot, compare registers and the result register.
// ----------------------------------------------------------------------------
module rsas_dp import rsas_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  in_item_t           request,
  input  logic [COUNT_W-1:0] element_count,
  input  dp_cmd_t            cmd,
  output flags_t             flags,
  output logic               result_valid,
  output out_item_t          result
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned XW = ((AW > COUNT_W) ? AW : COUNT_W) + 2;
  localparam logic signed [XW-1:0] ONE  = XW'(1);
  localparam logic signed [XW-1:0] ZERO = XW'(0);
  localparam logic [XW-1:0]        CAP  = XW'(MAX_ELEMENTS);

  logic signed [31:0] mem [MAX_ELEMENTS];

  logic signed [XW-1:0] lo;
  logic signed [XW-1:0] hi;
  logic signed [XW-1:0] p;
  logic signed [XW-1:0] n;
  logic signed [XW-1:0] mid;
  logic signed [XW-1:0] addr_x;
  logic signed [XW-1:0] n_eff;
  logic [XW-1:0]        cnt_ext;
  logic [XW-1:0]        idx_ext;
  logic signed [31:0]   a_val;
  logic signed [31:0]   rdata;
  logic signed [31:0]   target;
  logic                 wr_en;

  assign mid = lo + ((hi - lo) >>> 1);

  assign cnt_ext = {{(XW-COUNT_W){1'b0}}, element_count};
  assign n_eff   = (cnt_ext > CAP) ? CAP : cnt_ext;
  assign idx_ext = {{(XW-8){1'b0}}, request.load_index};
  assign wr_en   = accept && (request.op == OP_LOAD) && (idx_ext < CAP);

  always_comb begin
    case (cmd.addr_sel)
      AD_MID:    addr_x = mid;
      AD_MID_P1: addr_x = mid + ONE;
      AD_MID_M1: addr_x = mid - ONE;
      AD_LO:     addr_x = lo;
      AD_P:      addr_x = p;
      AD_ZERO:   addr_x = ZERO;
      default:   addr_x = mid;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_ext[AW-1:0]] <= request.value;
    end
    rdata <= mem[addr_x[AW-1:0]];
  end

  assign flags.cnt_zero = (n_eff == ZERO);
  assign flags.lo_ge_hi = (lo >= hi);
  assign flags.lo_gt_hi = (lo > hi);
  assign flags.piv_next = ((mid + ONE) < n) && (a_val > rdata);
  assign flags.piv_prev = (mid >= ONE) && (a_val < rdata);
  assign flags.left     = (a_val >= target) && (rdata <= target);
  assign flags.rd_eq_v  = (rdata == target);

  always_ff @(posedge clk) begin
    if (cmd.a_load) begin
      a_val <= rdata;
    end
    if (accept && (request.op == OP_QUERY)) begin
      lo     <= ZERO;
      hi     <= n_eff - ONE;
      n      <= n_eff;
      target <= request.value;
      result <= '{found: 1'b0, position: 8'd0};
    end
    case (cmd.act)
      A_P_END:    p <= (lo == hi) ? lo : (n - ONE);
      A_P_MID:    p <= mid;
      A_P_MIDM1:  p <= mid - ONE;
      A_NARROW_A: begin
        if (rdata > a_val) begin
          hi <= mid - ONE;
        end else begin
          lo <= mid + ONE;
        end
      end
      A_NARROW_V: begin
        if (rdata > target) begin
          hi <= mid - ONE;
        end else begin
          lo <= mid + ONE;
        end
      end
      A_RANGE_L: begin
        lo <= ZERO;
        hi <= p;
      end
      A_RANGE_R: begin
        lo <= p + ONE;
        hi <= n - ONE;
      end
      A_HIT:      result <= '{found: 1'b1, position: mid[7:0]};
      A_MISS:     result <= '{found: 1'b0, position: 8'd0};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.act == A_HIT) || (cmd.act == A_MISS) ||
                      (accept && (request.op == OP_QUERY) && (n_eff == ZERO));
    end
  end

`ifndef SYNTHESIS
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == A_HIT) |-> (lo <= mid && mid <= hi))
    else $error("hit outside search bounds");

  a_pivot_mid_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == A_P_MID) |-> (mid >= ZERO && mid < n))
    else $error("pivot outside array");

  a_pivot_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == A_RANGE_L || cmd.act == A_RANGE_R) |-> (p >= ZERO && p < n))
    else $error("pivot out of range at half select");
`endif

endmodule

// ===== src/rotated_sorted_array_search.sv =====
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// Search of a rotated ascending array: pivot search followed by a binary
// search of the half that can hold the target.
// ----------------------------------------------------------------------------
// A load item gives no result. A query keeps busy high through the pivot
// search steps PV0 to PV4 for each halving, the half select steps SL0 to SL2
// and the final search steps BS0 and BS1 for each halving; the single read
// port of the element memory, one read per microcode step, sets these steps.
// The result strobe lasts one cycle, cannot be stalled, and comes in the
// first cycle with busy low. A query with an element count of zero answers not
// found in the cycle after it is accepted. Write the count only while idle.
module rotated_sorted_array_search import rsas_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  in_item_t           request,
  output logic               result_valid,
  output out_item_t          result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] element_count;
  logic               accept;
  flags_t             flags;
  dp_cmd_t            cmd;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      element_count <= cfg_data;
    end
  end

  rsas_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (request.op),
    .flags (flags),
    .busy  (busy),
    .cmd   (cmd)
  );

  rsas_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .request       (request),
    .element_count (element_count),
    .cmd           (cmd),
    .flags         (flags),
    .result_valid  (result_valid),
    .result        (result)
  );

`ifndef SYNTHESIS
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  a_busy_ends_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid)
    else $error("query ended without a result");

  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while a query runs");
`endif

endmodule
